// ===== hdl/vpu_pkg.sv =====
package vpu_pkg;

   localparam int COMP_WIDTH_DEF = 24;

   // Quotient bits kept by the dividers: results stay below 2^(w+1)
   function automatic int quot_width(input int w);
      return w + 2;
   endfunction

endpackage

// ===== hdl/vpu_if.sv =====
interface vpu_req_if #(
   parameter int COMP_WIDTH = vpu_pkg::COMP_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] j_x;
   logic signed [COMP_WIDTH-1:0] j_y;
   logic signed [COMP_WIDTH-1:0] j_z;
   logic signed [COMP_WIDTH-1:0] r_x;
   logic signed [COMP_WIDTH-1:0] r_y;
   logic signed [COMP_WIDTH-1:0] r_z;

   modport source (output valid, j_x, j_y, j_z, r_x, r_y, r_z, input ready);
   modport sink (input valid, j_x, j_y, j_z, r_x, r_y, r_z, output ready);
endinterface

interface vpu_rsp_if #(
   parameter int COMP_WIDTH = vpu_pkg::COMP_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] p_x;
   logic signed [COMP_WIDTH-1:0] p_y;
   logic signed [COMP_WIDTH-1:0] p_z;
   logic signed [COMP_WIDTH-1:0] proj_length;
   logic                         dir_zero;
   logic                         saturated;

   modport source (output valid, p_x, p_y, p_z, proj_length, dir_zero, saturated,
                   input ready);
   modport sink (input valid, p_x, p_y, p_z, proj_length, dir_zero, saturated,
                 output ready);
endinterface

// ===== hdl/vpu_front.sv =====
module vpu_front #(
   parameter int W    = vpu_pkg::COMP_WIDTH_DEF,
   parameter int NUMW = 3 * W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              v_i,
   input  logic [W-1:0]      j_i [3],
   input  logic [W-1:0]      r_i [3],
   output logic              v_o,
   output logic [NUMW-1:0]   num_o [3],
   output logic [2*W-1:0]    dmag_o,
   output logic [2*W-1:0]    nsq_o,
   output logic              dneg_o,
   output logic [2:0]        nr_o,
   output logic              zero_o
);
   localparam int PW = 2 * W;

   logic [5:0]     v_ff;
   // stage 1: magnitudes
   logic [W-1:0]   mj1_ff [3];
   logic [W-1:0]   mr1_ff [3];
   logic [2:0]     nj1_ff, nr1_ff;
   // stage 2: products
   logic [PW-1:0]  pjr2_ff [3];
   logic [PW-1:0]  prr2_ff [3];
   logic [2:0]     pn2_ff, nr2_ff;
   logic [W-1:0]   mr2_ff [3];
   // stage 3: sums
   logic [PW-1:0]  pos3_ff, neg3_ff, nsq3_ff;
   logic [PW-1:0]  pos3_in, neg3_in, nsq3_in;
   logic [2:0]     nr3_ff;
   logic [W-1:0]   mr3_ff [3];
   // stage 4: signed dot magnitude
   logic [PW-1:0]  dmag4_ff, nsq4_ff;
   logic           dneg4_ff, zero4_ff;
   logic [2:0]     nr4_ff;
   logic [W-1:0]   mr4_ff [3];
   // stage 5: partial products
   logic [PW-1:0]  lo5_ff [3];
   logic [PW-1:0]  hi5_ff [3];
   logic [PW-1:0]  dmag5_ff, nsq5_ff;
   logic           dneg5_ff, zero5_ff;
   logic [2:0]     nr5_ff;
   // stage 6: numerators
   logic [NUMW-1:0] num6_ff [3];
   logic [PW-1:0]  dmag6_ff, nsq6_ff;
   logic           dneg6_ff, zero6_ff;
   logic [2:0]     nr6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], v_i};
      end
   end

   always_comb begin
      pos3_in = '0;
      neg3_in = '0;
      nsq3_in = '0;
      for (int c = 0; c < 3; c++) begin
         if (pn2_ff[c]) begin
            neg3_in = neg3_in + pjr2_ff[c];
         end else begin
            pos3_in = pos3_in + pjr2_ff[c];
         end
         nsq3_in = nsq3_in + prr2_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            mj1_ff[c] <= j_i[c][W-1] ? W'(-j_i[c]) : j_i[c];
            mr1_ff[c] <= r_i[c][W-1] ? W'(-r_i[c]) : r_i[c];
            nj1_ff[c] <= j_i[c][W-1];
            nr1_ff[c] <= r_i[c][W-1];

            pjr2_ff[c] <= PW'(mj1_ff[c]) * PW'(mr1_ff[c]);
            prr2_ff[c] <= PW'(mr1_ff[c]) * PW'(mr1_ff[c]);
            mr2_ff[c]  <= mr1_ff[c];
            mr3_ff[c]  <= mr2_ff[c];
            mr4_ff[c]  <= mr3_ff[c];

            lo5_ff[c] <= PW'(dmag4_ff[W-1:0]) * PW'(mr4_ff[c]);
            hi5_ff[c] <= PW'(dmag4_ff[PW-1:W]) * PW'(mr4_ff[c]);

            num6_ff[c] <= NUMW'(lo5_ff[c]) + {hi5_ff[c], {W{1'b0}}};
         end
         pn2_ff <= nj1_ff ^ nr1_ff;
         nr2_ff <= nr1_ff;

         pos3_ff <= pos3_in;
         neg3_ff <= neg3_in;
         nsq3_ff <= nsq3_in;
         nr3_ff  <= nr2_ff;

         dneg4_ff <= neg3_ff > pos3_ff;
         dmag4_ff <= (neg3_ff > pos3_ff) ? (neg3_ff - pos3_ff) : (pos3_ff - neg3_ff);
         zero4_ff <= nsq3_ff == '0;
         nsq4_ff  <= nsq3_ff;
         nr4_ff   <= nr3_ff;

         dmag5_ff <= dmag4_ff;
         nsq5_ff  <= nsq4_ff;
         dneg5_ff <= dneg4_ff;
         zero5_ff <= zero4_ff;
         nr5_ff   <= nr4_ff;

         dmag6_ff <= dmag5_ff;
         nsq6_ff  <= nsq5_ff;
         dneg6_ff <= dneg5_ff;
         zero6_ff <= zero5_ff;
         nr6_ff   <= nr5_ff;
      end
   end

   assign v_o    = v_ff[5];
   assign num_o  = num6_ff;
   assign dmag_o = dmag6_ff;
   assign nsq_o  = nsq6_ff;
   assign dneg_o = dneg6_ff;
   assign nr_o   = nr6_ff;
   assign zero_o = zero6_ff;
endmodule

// ===== hdl/vpu_sqrt.sv =====
module vpu_sqrt #(
   parameter int W  = vpu_pkg::COMP_WIDTH_DEF,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            v_i,
   input  logic [2*W-1:0]  n_i,
   input  logic [SW-1:0]   side_i,
   output logic            v_o,
   output logic [W-1:0]    root_o,
   output logic [2*W-1:0]  n_o,
   output logic [SW-1:0]   side_o
);
   // one result bit per stage
   logic [W-1:0]   v_ff;
   logic [W+1:0]   rem_ff  [W];
   logic [W-1:0]   root_ff [W];
   logic [2*W-1:0] n_ff    [W];
   logic [SW-1:0]  side_ff [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      localparam int I = W - 1 - k;
      logic [W+1:0]   pr, t, trial;
      logic [W-1:0]   prt;
      logic [2*W-1:0] pn;
      logic [SW-1:0]  ps;
      logic           pv;

      if (k == 0) begin : g_first
         assign pr  = '0;
         assign prt = '0;
         assign pn  = n_i;
         assign ps  = side_i;
         assign pv  = v_i;
      end else begin : g_next
         assign pr  = rem_ff[k-1];
         assign prt = root_ff[k-1];
         assign pn  = n_ff[k-1];
         assign ps  = side_ff[k-1];
         assign pv  = v_ff[k-1];
      end

      assign t     = {pr[W-1:0], pn[2*I+1 -: 2]};
      assign trial = {prt, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (t >= trial) begin
               rem_ff[k]  <= t - trial;
               root_ff[k] <= {prt[W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= t;
               root_ff[k] <= {prt[W-2:0], 1'b0};
            end
            n_ff[k]    <= pn;
            side_ff[k] <= ps;
         end
      end
   end

   assign v_o    = v_ff[W-1];
   assign root_o = root_ff[W-1];
   assign n_o    = n_ff[W-1];
   assign side_o = side_ff[W-1];
endmodule

// ===== hdl/vpu_div.sv =====
module vpu_div #(
   parameter int QW    = 26,
   parameter int NUMW  = 72,
   parameter int DW    = 48,
   parameter int LANES = 4,
   parameter int SW    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             v_i,
   input  logic [NUMW-1:0]  num_i [LANES],
   input  logic [DW-1:0]    den_i [LANES],
   input  logic [SW-1:0]    side_i,
   output logic             v_o,
   output logic [QW-1:0]    q_o [LANES],
   output logic [SW-1:0]    side_o
);
   // restoring division, one quotient bit per stage; quotient known below 2^QW
   logic [QW-1:0]   v_ff;
   logic [DW-1:0]   rem_ff [QW][LANES];
   logic [QW-1:0]   q_ff   [QW][LANES];
   logic [NUMW-1:0] num_ff [QW][LANES];
   logic [DW-1:0]   den_ff [QW][LANES];
   logic [SW-1:0]   side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic [DW-1:0]   pr  [LANES];
      logic [QW-1:0]   pq  [LANES];
      logic [NUMW-1:0] pn  [LANES];
      logic [DW-1:0]   pd  [LANES];
      logic [SW-1:0]   ps;
      logic            pv;

      if (k == 0) begin : g_first
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign pr[l] = DW'(num_i[l] >> QW);
            assign pq[l] = '0;
            assign pn[l] = num_i[l];
            assign pd[l] = den_i[l];
         end
         assign ps = side_i;
         assign pv = v_i;
      end else begin : g_next
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign pr[l] = rem_ff[k-1][l];
            assign pq[l] = q_ff[k-1][l];
            assign pn[l] = num_ff[k-1][l];
            assign pd[l] = den_ff[k-1][l];
         end
         assign ps = side_ff[k-1];
         assign pv = v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         logic [DW:0] t;
         if (en) begin
            for (int l = 0; l < LANES; l++) begin
               t = {pr[l], pn[l][B]};
               if (t >= {1'b0, pd[l]}) begin
                  rem_ff[k][l] <= DW'(t - {1'b0, pd[l]});
                  q_ff[k][l]   <= {pq[l][QW-2:0], 1'b1};
               end else begin
                  rem_ff[k][l] <= t[DW-1:0];
                  q_ff[k][l]   <= {pq[l][QW-2:0], 1'b0};
               end
               num_ff[k][l] <= pn[l];
               den_ff[k][l] <= pd[l];
            end
            side_ff[k] <= ps;
         end
      end
   end

   assign v_o    = v_ff[QW-1];
   assign q_o    = q_ff[QW-1];
   assign side_o = side_ff[QW-1];
endmodule

// ===== hdl/vpu_back.sv =====
module vpu_back #(
   parameter int W  = vpu_pkg::COMP_WIDTH_DEF,
   parameter int QW = W + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          v_i,
   input  logic [QW-1:0] q_i [4],
   input  logic [3:0]    neg_i,
   input  logic          zero_i,
   output logic          v_o,
   output logic [W-1:0]  val_o [4],
   output logic          zero_o,
   output logic          sat_o
);
   logic         v_ff;
   logic [W-1:0] val_ff [4];
   logic [W-1:0] val_in [4];
   logic         zero_ff, sat_ff, sat_in;

   always_comb begin
      logic [QW-1:0] lim, mag;
      sat_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         lim = neg_i[c] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
         mag = q_i[c];
         if (mag > lim) begin
            mag    = lim;
            sat_in = 1'b1;
         end
         val_in[c] = neg_i[c] ? W'(-mag[W-1:0]) : mag[W-1:0];
         if (zero_i) begin
            val_in[c] = '0;
         end
      end
      if (zero_i) begin
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         zero_ff <= zero_i;
         sat_ff  <= sat_in;
      end
   end

   assign v_o    = v_ff;
   assign val_o  = val_ff;
   assign zero_o = zero_ff;
   assign sat_o  = sat_ff;
endmodule

// ===== hdl/vector_projection_unit.sv =====
// Projects vector J onto direction R: p = dot(J,R)*R/|R|^2 per component and
// proj_length = dot(J,R)/floor(|R|), all truncated toward zero and saturated.
// Fully pipelined: one transfer accepted per cycle while the output is not stalled, built
// from six front stages (magnitudes, products, sums, dot sign, two-part
// numerator multiply), a COMP_WIDTH-stage square root, a (COMP_WIDTH+2)-stage
// divider array and the output register. When the output is stalled the whole
// pipeline holds. A zero R gives zero results and dir_zero.
module vector_projection_unit #(
   parameter int COMP_WIDTH = vpu_pkg::COMP_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   vpu_req_if.sink   req,
   vpu_rsp_if.source rsp
);
   localparam int W    = COMP_WIDTH;
   localparam int PW   = 2 * W;
   localparam int NUMW = 3 * W;
   localparam int QW   = vpu_pkg::quot_width(W);
   localparam int SW   = 5 + PW + 3 * NUMW;

   logic            en;
   logic [W-1:0]    j_vec [3];
   logic [W-1:0]    r_vec [3];
   logic            f_v, f_dneg, f_zero;
   logic [NUMW-1:0] f_num [3];
   logic [PW-1:0]   f_dmag, f_nsq;
   logic [2:0]      f_nr;
   logic [SW-1:0]   s_side_in, s_side;
   logic            s_v;
   logic [W-1:0]    s_root;
   logic [PW-1:0]   s_nsq;
   logic [NUMW-1:0] d_num [4];
   logic [PW-1:0]   d_den [4];
   logic [4:0]      d_side_in, d_side;
   logic            d_v;
   logic [QW-1:0]   d_q [4];
   logic [W-1:0]    b_val [4];

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   assign j_vec = '{req.j_x, req.j_y, req.j_z};
   assign r_vec = '{req.r_x, req.r_y, req.r_z};

   vpu_front #(.W(W), .NUMW(NUMW)) u_front (
      .clock(clock), .reset(reset), .en(en),
      .v_i(req.valid && en), .j_i(j_vec), .r_i(r_vec),
      .v_o(f_v), .num_o(f_num), .dmag_o(f_dmag), .nsq_o(f_nsq),
      .dneg_o(f_dneg), .nr_o(f_nr), .zero_o(f_zero)
   );

   assign s_side_in = {f_zero, f_dneg, f_nr, f_dmag, f_num[2], f_num[1], f_num[0]};

   vpu_sqrt #(.W(W), .SW(SW)) u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .v_i(f_v), .n_i(f_nsq), .side_i(s_side_in),
      .v_o(s_v), .root_o(s_root), .n_o(s_nsq), .side_o(s_side)
   );

   // component lanes divide by the exact squared length
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d_num[c] = s_side[c*NUMW +: NUMW];
      end
      d_num[3] = NUMW'(s_side[3*NUMW +: PW]);
      d_den[3] = PW'(s_root);
      for (int c = 0; c < 3; c++) begin
         d_den[c] = s_nsq;
      end
   end

   // neg per lane: dot sign xor component sign; length lane takes the dot sign
   assign d_side_in = {s_side[SW-1], s_side[SW-2],
                       s_side[SW-2] ^ s_side[SW-3],
                       s_side[SW-2] ^ s_side[SW-4],
                       s_side[SW-2] ^ s_side[SW-5]};

   vpu_div #(.QW(QW), .NUMW(NUMW), .DW(PW), .LANES(4), .SW(5)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .v_i(s_v), .num_i(d_num), .den_i(d_den), .side_i(d_side_in),
      .v_o(d_v), .q_o(d_q), .side_o(d_side)
   );

   vpu_back #(.W(W), .QW(QW)) u_back (
      .clock(clock), .reset(reset), .en(en),
      .v_i(d_v), .q_i(d_q), .neg_i(d_side[3:0]), .zero_i(d_side[4]),
      .v_o(rsp.valid), .val_o(b_val), .zero_o(rsp.dir_zero), .sat_o(rsp.saturated)
   );

   assign rsp.p_x         = b_val[0];
   assign rsp.p_y         = b_val[1];
   assign rsp.p_z         = b_val[2];
   assign rsp.proj_length = b_val[3];

   localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.dir_zero |-> rsp.p_x == '0 && rsp.p_y == '0 && rsp.p_z == '0
         && rsp.proj_length == '0 && !rsp.saturated)
      else $error("zero direction with nonzero result");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         rsp.p_x == MAX_VAL || rsp.p_x == MIN_VAL || rsp.p_y == MAX_VAL
         || rsp.p_y == MIN_VAL || rsp.p_z == MAX_VAL || rsp.p_z == MIN_VAL
         || rsp.proj_length == MAX_VAL || rsp.proj_length == MIN_VAL)
      else $error("saturated flag without clipped value");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");
endmodule
